// ===== rtl/pse_pkg.sv =====
// Package for the postfix stack evaluator: payload structs, stack cell commands,
// controller states, character codes and a small helper function.
// No dependencies.
package pse_pkg;

  localparam int PSE_STACK_DEPTH = 16;
  localparam int PSE_FRAC_BITS   = 16;
  localparam int VAL_W           = 64;

  // Opcode of an input transaction.
  localparam logic OPC_CHAR = 1'b0;
  localparam logic OPC_END  = 1'b1;

  // Result status.
  localparam logic STS_OK    = 1'b0;
  localparam logic STS_ERROR = 1'b1;

  // Expression characters.
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TRIPLE = 8'h68;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUAD   = 8'h66;
  localparam logic [7:0] CH_MAC    = 8'h67;

  typedef struct packed {
    logic       opcode;
    logic [7:0] symbol;
  } pse_in_t;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] result_value;
  } pse_out_t;

  // What a stack cell loads in a cycle.
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_TAKE_PREV,
    STK_TAKE_NEXT1,
    STK_TAKE_NEXT2
  } stk_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_ADD
  } pse_state_t;

  // Status handed back by the multiplier.
  typedef struct packed {
    logic             done;
    logic             bad;
    logic [VAL_W-1:0] value;
  } mul_res_t;

  function automatic logic [VAL_W-1:0] mag64(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

endpackage

// ===== rtl/pse_cell.sv =====
// One entry of the shifting operand stack.
// Depends on pse_pkg for the cell command type.
module pse_cell
  import pse_pkg::*;
(
  input  logic             clk,
  input  stk_cmd_t         cmd,
  input  logic [VAL_W-1:0] prev_val,
  input  logic [VAL_W-1:0] next1_val,
  input  logic [VAL_W-1:0] next2_val,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  always_comb begin
    case (cmd)
      STK_TAKE_PREV:  val_nxt = prev_val;
      STK_TAKE_NEXT1: val_nxt = next1_val;
      STK_TAKE_NEXT2: val_nxt = next2_val;
      default:        val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/pse_mul.sv =====
// Multi-cycle fixed-point multiplier: four 32x32 partial products, a 128-bit
// accumulator, then scaling and range check. Depends on pse_pkg.
module pse_mul
  import pse_pkg::*;
#(
  parameter int FRAC_BITS = PSE_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] x_mag,
  input  logic [VAL_W-1:0] y_mag,
  input  logic             neg,
  output mul_res_t         res
);

  localparam int          HALF_W    = VAL_W / 2;
  localparam int          ACC_W     = 2 * VAL_W;
  localparam logic [2:0]  STEP_LAST_PP = 3'd3;
  localparam logic [2:0]  STEP_LAST_ACC = 3'd4;
  localparam logic [2:0]  STEP_CHECK = 3'd5;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        step_r;
  logic [VAL_W-1:0]  x_r;
  logic [VAL_W-1:0]  y_r;
  logic              neg_r;
  logic [VAL_W-1:0]  pp_r;
  logic [1:0]        pp_sh_r;
  logic [ACC_W-1:0]  acc_r;
  logic [VAL_W-1:0]  res_r;
  logic              bad_r;

  logic [HALF_W-1:0] x_half;
  logic [HALF_W-1:0] y_half;
  logic [VAL_W-1:0]  pp_nxt;
  logic [ACC_W-1:0]  pp_aligned;
  logic [ACC_W-1:0]  scaled;
  logic [VAL_W-1:0]  limit;
  logic              bad_nxt;
  logic [VAL_W-1:0]  res_nxt;

  // Step bit 1 picks the upper half of x, step bit 0 the upper half of y.
  assign x_half = step_r[1] ? x_r[VAL_W-1:HALF_W] : x_r[HALF_W-1:0];
  assign y_half = step_r[0] ? y_r[VAL_W-1:HALF_W] : y_r[HALF_W-1:0];
  assign pp_nxt = VAL_W'(x_half) * VAL_W'(y_half);

  always_comb begin
    case (pp_sh_r)
      2'd1:    pp_aligned = ACC_W'(pp_r) << HALF_W;
      2'd2:    pp_aligned = ACC_W'(pp_r) << VAL_W;
      default: pp_aligned = ACC_W'(pp_r);
    endcase
  end

  // Truncate the fraction of the magnitude, then check against the signed range.
  assign scaled  = acc_r >> FRAC_BITS;
  assign limit   = neg_r ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  assign bad_nxt = (scaled[ACC_W-1:VAL_W] != '0) || (scaled[VAL_W-1:0] > limit);
  assign res_nxt = neg_r ? (~scaled[VAL_W-1:0] + VAL_W'(1)) : scaled[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_CHECK) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x_mag;
      y_r   <= y_mag;
      neg_r <= neg;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r <= STEP_LAST_PP) begin
        pp_r    <= pp_nxt;
        pp_sh_r <= 2'(step_r[1]) + 2'(step_r[0]);
      end
      if (step_r != '0 && step_r <= STEP_LAST_ACC) begin
        acc_r <= acc_r + pp_aligned;
      end
      if (step_r == STEP_CHECK) begin
        res_r <= res_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  assign res.done  = done_r;
  assign res.bad   = bad_r;
  assign res.value = res_r;

endmodule

// ===== rtl/postfix_stack_evaluator_core.sv =====
// Postfix stack evaluator, top level.
// Digits, 'h', '+', '-', unknown characters and end transactions are handled in the
// idle state. 'f' and 'g' go on through the shared multiplier (four partial
// products, accumulate, scale and check, done handoff) and then the subtract and
// add steps; no new transaction is taken until they are done.
// An end transaction's result appears in the output register the next cycle.
// Synchronous active-low reset empties the stack, clears the error and the output valid flag.
module postfix_stack_evaluator_core
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = PSE_STACK_DEPTH,
  parameter int FRAC_BITS   = PSE_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pse_out_t out_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // The stack is a row of cells with the top in cell 0. A push shifts every
  // cell one place deeper; an operator writes its result into cell 0 while the
  // deeper cells move up by one less than the number of operands it consumed.
  logic [VAL_W-1:0] cell_val [STACK_DEPTH];
  stk_cmd_t         top_cmd;
  stk_cmd_t         rest_cmd;
  logic [VAL_W-1:0] top_in;

  pse_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic             is_quad_r, is_quad_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  pse_out_t         out_data_r, out_data_nxt;

  logic             in_fire;
  logic             mul_start;
  logic [VAL_W-1:0] mul_x;
  logic [VAL_W-1:0] mul_y;
  logic             mul_neg;
  mul_res_t         mul_res;

  logic [VAL_W-1:0] op_c;
  logic [VAL_W-1:0] op_b;
  logic [VAL_W-1:0] op_a;
  logic             sym_is_fg;
  logic [VAL_W+1:0] triple;
  logic [VAL_W:0]   sum_ab;
  logic [VAL_W:0]   dif_ab;
  logic [VAL_W:0]   b_adj;
  logic [VAL_W-1:0] b_half;
  logic [VAL_W:0]   quad_dif;
  logic [VAL_W:0]   fin_sum;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [VAL_W-1:0] prev_v;
      logic [VAL_W-1:0] next1_v;
      logic [VAL_W-1:0] next2_v;
      if (gi == 0) begin : g_top
        assign prev_v = top_in;
      end else begin : g_mid
        assign prev_v = cell_val[gi-1];
      end
      if (gi + 1 < STACK_DEPTH) begin : g_n1
        assign next1_v = cell_val[gi+1];
      end else begin : g_n1z
        assign next1_v = '0;
      end
      if (gi + 2 < STACK_DEPTH) begin : g_n2
        assign next2_v = cell_val[gi+2];
      end else begin : g_n2z
        assign next2_v = '0;
      end
      pse_cell u_cell (
        .clk       (clk),
        .cmd       ((gi == 0) ? top_cmd : rest_cmd),
        .prev_val  (prev_v),
        .next1_val (next1_v),
        .next2_val (next2_v),
        .val       (cell_val[gi])
      );
    end
  endgenerate

  // Operands: c is the top, b below it, a the deepest of three.
  assign op_c = cell_val[0];
  assign op_b = cell_val[1];
  assign op_a = cell_val[2];

  assign sym_is_fg = (in_data.symbol == CH_QUAD) || (in_data.symbol == CH_MAC);

  // A character transaction may enter while a result still waits; an end
  // transaction needs the output register to be free or draining.
  assign in_ready = (state_r == ST_IDLE) &&
                    (!out_valid_r || out_ready || (in_data.opcode == OPC_CHAR));
  assign in_fire  = in_valid && in_ready;

  // Exact-width datapath for the 'h', '+' and '-' operators.
  assign triple = {{2{op_c[VAL_W-1]}}, op_c} + {op_c[VAL_W-1], op_c, 1'b0};
  assign sum_ab = {op_b[VAL_W-1], op_b} + {op_c[VAL_W-1], op_c};
  assign dif_ab = {op_b[VAL_W-1], op_b} - {op_c[VAL_W-1], op_c};

  // b/2 rounds toward zero: bias negative values by one before the shift.
  assign b_adj    = {op_b[VAL_W-1], op_b} + (VAL_W+1)'(op_b[VAL_W-1]);
  assign b_half   = b_adj[VAL_W:1];
  assign quad_dif = {mul_res.value[VAL_W-1], mul_res.value} - {b_half[VAL_W-1], b_half};
  assign fin_sum  = {acc_r[VAL_W-1], acc_r} + {op_c[VAL_W-1], op_c};

  assign mul_x   = mag64(op_a);
  assign mul_y   = (in_data.symbol == CH_QUAD) ? mag64(op_a) : mag64(op_b);
  assign mul_neg = (in_data.symbol == CH_QUAD) ? 1'b0 : (op_a[VAL_W-1] ^ op_b[VAL_W-1]);

  pse_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x_mag (mul_x),
    .y_mag (mul_y),
    .neg   (mul_neg),
    .res   (mul_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.opcode == OPC_CHAR && !err_r && sym_is_fg &&
            cnt_r >= CNT_W'(3)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_res.done) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    top_cmd       = STK_HOLD;
    rest_cmd      = STK_HOLD;
    top_in        = '0;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    is_quad_nxt   = is_quad_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    mul_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.opcode == OPC_END) begin
          out_valid_nxt = 1'b1;
          if (!err_r && cnt_r == CNT_W'(1)) begin
            out_data_nxt.status       = STS_OK;
            out_data_nxt.result_value = op_c;
          end else begin
            out_data_nxt.status       = STS_ERROR;
            out_data_nxt.result_value = '0;
          end
          cnt_nxt = '0;
          err_nxt = 1'b0;
        end else if (in_fire && !err_r) begin
          case (in_data.symbol) inside
            [CH_ZERO:CH_NINE]: begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                err_nxt = 1'b1;
              end else begin
                top_in   = VAL_W'(4'(in_data.symbol - CH_ZERO)) << FRAC_BITS;
                top_cmd  = STK_TAKE_PREV;
                rest_cmd = STK_TAKE_PREV;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            CH_TRIPLE: begin
              if (cnt_r == '0 || (triple[VAL_W+1:VAL_W-1] != '0 &&
                                  triple[VAL_W+1:VAL_W-1] != '1)) begin
                err_nxt = 1'b1;
              end else begin
                top_in  = triple[VAL_W-1:0];
                top_cmd = STK_TAKE_PREV;
              end
            end
            CH_PLUS, CH_MINUS: begin
              if (cnt_r < CNT_W'(2)) begin
                err_nxt = 1'b1;
              end else if (in_data.symbol == CH_PLUS) begin
                if (sum_ab[VAL_W] != sum_ab[VAL_W-1]) begin
                  err_nxt = 1'b1;
                end else begin
                  top_in   = sum_ab[VAL_W-1:0];
                  top_cmd  = STK_TAKE_PREV;
                  rest_cmd = STK_TAKE_NEXT1;
                  cnt_nxt  = cnt_r - CNT_W'(1);
                end
              end else begin
                if (dif_ab[VAL_W] != dif_ab[VAL_W-1]) begin
                  err_nxt = 1'b1;
                end else begin
                  top_in   = dif_ab[VAL_W-1:0];
                  top_cmd  = STK_TAKE_PREV;
                  rest_cmd = STK_TAKE_NEXT1;
                  cnt_nxt  = cnt_r - CNT_W'(1);
                end
              end
            end
            CH_QUAD, CH_MAC: begin
              if (cnt_r < CNT_W'(3)) begin
                err_nxt = 1'b1;
              end else begin
                mul_start   = 1'b1;
                is_quad_nxt = (in_data.symbol == CH_QUAD);
              end
            end
            default: err_nxt = 1'b1;
          endcase
        end
      end
      ST_SUB: begin
        // For 'f' take away b/2; 'g' passes the product straight on.
        if (is_quad_r) begin
          acc_nxt = quad_dif[VAL_W-1:0];
          bad_nxt = mul_res.bad || (quad_dif[VAL_W] != quad_dif[VAL_W-1]);
        end else begin
          acc_nxt = mul_res.value;
          bad_nxt = mul_res.bad;
        end
      end
      ST_ADD: begin
        if (bad_r || fin_sum[VAL_W] != fin_sum[VAL_W-1]) begin
          err_nxt = 1'b1;
        end else begin
          top_in   = fin_sum[VAL_W-1:0];
          top_cmd  = STK_TAKE_PREV;
          rest_cmd = STK_TAKE_NEXT2;
          cnt_nxt  = cnt_r - CNT_W'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_quad_r  <= is_quad_nxt;
    acc_r      <= acc_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_postfix_stack_evaluator_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for postfix_stack_evaluator_core: directed and random expressions.
// Depends on pse_pkg and the evaluator RTL; nothing else is read or needed.
module tb_postfix_stack_evaluator_core;
  import pse_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 1950;
  // A quad or multiply-add step is the slowest step, so DRAIN_CYCLES of quiet after
  // the last result is plenty to catch a stray extra result.
  localparam int DRAIN_CYCLES = 32;
  // The slowest correct run stays far below this limit.
  localparam int CYCLE_LIMIT  = 500000;

  // Result of one checked fixed-point step: the wrapped value and an overflow flag.
  typedef struct packed {
    bit                      ovf;
    logic signed [VAL_W-1:0] v;
  } q_res_t;

  // One row of the directed table; typed rows carry a hand-written expected result.
  typedef struct {
    pse_in_t  item;
    bit       typed;
    pse_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pse_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pse_out_t out_data;

  // Predictor state: its own operand stack, depth and sticky error flag.
  logic signed [VAL_W-1:0] oper_stk [PSE_STACK_DEPTH];
  int                      oper_depth = 0;
  bit                      expr_err = 1'b0;

  pse_out_t pending_results[$];
  dir_row_t dir_rows[$];
  int       live_items = 0;
  int       fail_count = 0;
  int       cycle_cnt = 0;
  bit       in_burst = 1'b0;
  bit       out_burst = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  postfix_stack_evaluator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Signed 64-bit add and subtract, flagged when the true result leaves the range.
  function automatic q_res_t add_q(input logic signed [VAL_W-1:0] a, b);
    logic [VAL_W:0] s;
    q_res_t         r;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    r.ovf = s[VAL_W] ^ s[VAL_W-1];
    r.v = s[VAL_W-1:0];
    return r;
  endfunction

  function automatic q_res_t sub_q(input logic signed [VAL_W-1:0] a, b);
    logic [VAL_W:0] s;
    q_res_t         r;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    r.ovf = s[VAL_W] ^ s[VAL_W-1];
    r.v = s[VAL_W-1:0];
    return r;
  endfunction

  // Fixed-point product: multiply the magnitudes to full width, drop the fraction
  // bits (this truncates toward zero), then check the magnitude against the range
  // of the sign that the result will carry.
  function automatic q_res_t mul_q(input logic signed [VAL_W-1:0] a, b);
    logic [VAL_W-1:0]   ma;
    logic [VAL_W-1:0]   mb;
    logic [2*VAL_W-1:0] prod;
    logic [VAL_W-1:0]   lim;
    bit                 neg;
    q_res_t             r;
    neg = a[VAL_W-1] ^ b[VAL_W-1];
    ma = a[VAL_W-1] ? (~a + 64'd1) : a;
    mb = b[VAL_W-1] ? (~b + 64'd1) : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod >> PSE_FRAC_BITS;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    r.ovf = (prod[2*VAL_W-1:VAL_W] != '0) || (prod[VAL_W-1:0] > lim);
    if (r.ovf) begin
      r.v = '0;
    end else begin
      r.v = neg ? (~prod[VAL_W-1:0] + 64'd1) : prod[VAL_W-1:0];
    end
    return r;
  endfunction

  // Advances the predictor by one accepted transaction and reports the result
  // that an end transaction produces.
  task automatic apply_symbol(input pse_in_t it, output bit emits, output pse_out_t res);
    int                      n;
    logic [7:0]              c;
    logic signed [VAL_W-1:0] a_op;
    logic signed [VAL_W-1:0] b_op;
    logic signed [VAL_W-1:0] c_op;
    q_res_t                  t1;
    q_res_t                  t2;
    q_res_t                  t3;
    emits = 1'b0;
    res = '0;
    n = oper_depth;
    c = it.symbol;
    if (it.opcode == OPC_END) begin
      emits = 1'b1;
      if (!expr_err && n == 1) begin
        res.status = STS_OK;
        res.result_value = oper_stk[0];
      end else begin
        res.status = STS_ERROR;
        res.result_value = '0;
      end
      oper_depth = 0;
      expr_err = 1'b0;
    end else if (expr_err) begin
      // Characters after an error are dropped until the end transaction.
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (n >= PSE_STACK_DEPTH) begin
        expr_err = 1'b1;
      end else begin
        oper_stk[n] = 64'(c - CH_ZERO) << PSE_FRAC_BITS;
        oper_depth = n + 1;
      end
    end else if (c == CH_TRIPLE) begin
      if (n < 1) begin
        expr_err = 1'b1;
      end else begin
        t1 = add_q(oper_stk[n-1], oper_stk[n-1]);
        t2 = add_q(oper_stk[n-1], t1.v);
        if (t1.ovf || t2.ovf) expr_err = 1'b1;
        else oper_stk[n-1] = t2.v;
      end
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (n < 2) begin
        expr_err = 1'b1;
      end else begin
        a_op = oper_stk[n-2];
        b_op = oper_stk[n-1];
        t1 = (c == CH_PLUS) ? add_q(a_op, b_op) : sub_q(a_op, b_op);
        if (t1.ovf) begin
          expr_err = 1'b1;
        end else begin
          oper_stk[n-2] = t1.v;
          oper_depth = n - 1;
        end
      end
    end else if (c == CH_QUAD || c == CH_MAC) begin
      if (n < 3) begin
        expr_err = 1'b1;
      end else begin
        a_op = oper_stk[n-3];
        b_op = oper_stk[n-2];
        c_op = oper_stk[n-1];
        if (c == CH_QUAD) begin
          // a*a - b/2 + c; the halving truncates toward zero like the division.
          t1 = mul_q(a_op, a_op);
          t2 = sub_q(t1.v, b_op / 64'sd2);
        end else begin
          t1 = mul_q(a_op, b_op);
          t2 = t1;
        end
        t3 = add_q(t2.v, c_op);
        if (t1.ovf || t2.ovf || t3.ovf) begin
          expr_err = 1'b1;
        end else begin
          oper_stk[n-3] = t3.v;
          oper_depth = n - 2;
        end
      end
    end else begin
      expr_err = 1'b1;
    end
  endtask

  // Drives one transaction after a random gap and waits for the handshake. Ready
  // is sampled on the falling edge, where nothing is changing, and the transaction
  // is taken at the rising edge that follows.
  task automatic send_item(input pse_in_t it, input bit typed, input pse_out_t want);
    int       gap;
    bit       emits;
    pse_out_t predicted;
    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    // Characters swallowed by a pending error do not count as useful stimulus.
    if (it.opcode == OPC_END || !expr_err) live_items++;
    apply_symbol(it, emits, predicted);
    if (emits) pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_char(input logic [7:0] s);
    pse_in_t it;
    it.opcode = OPC_CHAR;
    it.symbol = s;
    send_item(it, 1'b0, '0);
  endtask

  // The symbol of an end transaction is ignored, so it is randomized.
  task automatic send_end();
    pse_in_t it;
    it.opcode = OPC_END;
    it.symbol = 8'($urandom_range(0, 255));
    send_item(it, 1'b0, '0);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic add_row(input logic op, input logic [7:0] sym, input bit typed,
                         input logic sts, input logic signed [VAL_W-1:0] val);
    dir_row_t r;
    r.item.opcode = op;
    r.item.symbol = sym;
    r.typed = typed;
    r.want.status = sts;
    r.want.result_value = val;
    dir_rows.push_back(r);
  endtask

  task automatic check_result(input pse_out_t got);
    pse_out_t w;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d, result_value %0d",
             got.status, $signed(got.result_value));
      fail_count++;
    end else begin
      w = pending_results.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, got.status);
        fail_count++;
      end
      if (got.result_value !== w.result_value) begin
        $error("result_value: expected %0d, actual %0d",
               $signed(w.result_value), $signed(got.result_value));
        fail_count++;
      end
    end
  endtask

  // Result side: a random stall before each result, with stretches of none, so
  // that results are held back at every phase of the evaluator's work.
  initial begin
    pse_out_t got;
    int       stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = out_data;
      @(posedge clk);
      check_result(got);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus: the directed table first, then random expressions.
  initial begin
    int         mode;
    int         depth;
    logic [7:0] s;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // An empty expression is an error.
    add_row(OPC_END,  8'h00,     1'b1, STS_ERROR, '0);
    // Largest and smallest digit on their own; the end symbol is a don't-care.
    add_row(OPC_CHAR, CH_NINE,   1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'hFF,     1'b1, STS_OK,    64'sh9_0000);
    add_row(OPC_CHAR, CH_ZERO,   1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h55,     1'b1, STS_OK,    '0);
    // (7 - 2 + 1) tripled is 18.
    add_row(OPC_CHAR, 8'h37,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h32,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, CH_MINUS,  1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h31,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, CH_PLUS,   1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, CH_TRIPLE, 1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h00,     1'b1, STS_OK,    64'sh12_0000);
    // Quad: 3*3 - 4/2 + 5 is 12.
    add_row(OPC_CHAR, 8'h33,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h34,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h35,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, CH_QUAD,   1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h00,     1'b1, STS_OK,    64'sh0C_0000);
    // Multiply-add: 2*3 + 4 is 10.
    add_row(OPC_CHAR, 8'h32,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h33,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, 8'h34,     1'b0, STS_OK,    '0);
    add_row(OPC_CHAR, CH_MAC,    1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h00,     1'b1, STS_OK,    64'sh0A_0000);
    // Underflow on an empty stack, then an unknown character.
    add_row(OPC_CHAR, CH_PLUS,   1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h00,     1'b1, STS_ERROR, '0);
    add_row(OPC_CHAR, 8'hFF,     1'b0, STS_OK,    '0);
    add_row(OPC_END,  8'h00,     1'b1, STS_ERROR, '0);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    while (live_items < dir_rows.size() + RANDOM_ITEMS) begin
      mode = $urandom_range(0, 99);
      depth = 0;
      if (mode < 60) begin
        // Well-formed expression with random digits and operators.
        repeat ($urandom_range(1, 24)) begin
          if (depth < 2 || (depth < PSE_STACK_DEPTH && $urandom_range(0, 1) == 1)) begin
            send_char(rand_digit());
            depth++;
          end else begin
            case ($urandom_range(0, (depth >= 3) ? 4 : 2))
              0: send_char(CH_TRIPLE);
              1: begin
                send_char(CH_PLUS);
                depth--;
              end
              2: begin
                send_char(CH_MINUS);
                depth--;
              end
              3: begin
                send_char(CH_QUAD);
                depth -= 2;
              end
              default: begin
                send_char(CH_MAC);
                depth -= 2;
              end
            endcase
          end
        end
      end else if (mode < 75) begin
        // Growth chains that run into the arithmetic overflow check, starting
        // from a positive or a negative value.
        if ($urandom_range(0, 1) == 1) begin
          send_char(CH_ZERO);
          send_char(CH_ZERO + 8'($urandom_range(1, 9)));
          send_char(CH_MINUS);
        end else begin
          send_char(rand_digit());
        end
        depth = 1;
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(20, 40)) send_char(CH_TRIPLE);
        end else begin
          repeat ($urandom_range(2, 7)) begin
            send_char(rand_digit());
            send_char(rand_digit());
            send_char(CH_QUAD);
          end
        end
      end else if (mode < 87) begin
        // Deep stack: up to full, and sometimes one or two digits past it.
        repeat ($urandom_range(14, 18)) begin
          send_char(rand_digit());
          depth++;
        end
        if (depth > PSE_STACK_DEPTH) depth = PSE_STACK_DEPTH;
      end else begin
        // Noise: any byte, known characters, and stray end transactions.
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 7) == 0) begin
            send_end();
          end else begin
            case ($urandom_range(0, 3))
              0: s = rand_digit();
              1: s = ($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS;
              2: s = ($urandom_range(0, 1) == 1) ? CH_QUAD : CH_MAC;
              default: s = 8'($urandom_range(0, 255));
            endcase
            send_char(s);
          end
        end
      end
      // Fold whatever the generator left on the stack down to one entry.
      while (depth > 1) begin
        if (depth >= 3 && $urandom_range(0, 1) == 1) begin
          send_char(($urandom_range(0, 1) == 1) ? CH_QUAD : CH_MAC);
          depth -= 2;
        end else begin
          send_char(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);
          depth--;
        end
      end
      send_end();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
